// ===== design/binary_mask_boundary_detect_core_assert.svh =====
// Assertion macros for the binary mask boundary detector.
// No dependencies; included by the files that carry assertions.
`ifndef BINARY_MASK_BOUNDARY_DETECT_CORE_ASSERT_SVH
`define BINARY_MASK_BOUNDARY_DETECT_CORE_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define BMBD_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("bmbd: same-cycle check failed");

// next-cycle implication
`define BMBD_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("bmbd: next-cycle check failed");

`else

`define BMBD_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons)
`define BMBD_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons)

`endif

`endif

// ===== design/bmbd_pkg.sv =====
// Shared types and constants of the binary mask boundary detector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmbd_pkg;

	// output field widths (coordinates are masked to these)
	localparam int COL_W = 10;
	localparam int ROW_W = 12;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 13;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1024;

	// line store entry bits
	localparam int LS_PREV  = 0;
	localparam int LS_OLDER = 1;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             flag;
		logic             last;
	} res_t;

	typedef struct packed {
		logic push0;
		logic push1;
	} push_t;

	typedef struct packed {
		logic load;
		logic use_alt;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/binary_mask_boundary_detect_core.sv =====
// Top level of the binary mask boundary detector: counters, window cells,
// line store and result queue. Uses bmbd_pkg, bmbd_cell, bmbd_line_store,
// bmbd_result_fifo and the assertion macro header.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | in_valid / in_ready    | gray
//  out     | out_valid / out_ready  | pixel_col, pixel_row, is_boundary,
//          |                        | last_of_run
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One pixel item is accepted per cycle while in_ready is high; results of a row are
// written into the result queue when the item of the row below is accepted.
// On the last row every item gives two results (one if the frame has one row); the single
// output port drains one per cycle while out_ready is high, so there in_ready holds the input back.
// The 4-entry result queue sets in_ready: an item is taken while at least 2 slots are free.
// Reset clears counters and the queue; the line store needs no clearing pass.
// Configuration writes are always accepted; writes to the width or height register restart the frame.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_mask_boundary_detect_core_assert.svh"

module binary_mask_boundary_detect_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// pixel input
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire  [7:0]                         gray,
	// results
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [bmbd_pkg::COL_W-1:0]         pixel_col,
	output logic [bmbd_pkg::ROW_W-1:0]         pixel_row,
	output logic                               is_boundary,
	output logic                               last_of_run,
	// configuration
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [bmbd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [bmbd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [bmbd_pkg::WIDTH_W-1:0]  width_q;
	logic [bmbd_pkg::HEIGHT_W-1:0] height_q;
	logic [CW-1:0]                 col_q, col_d, w_last, rd_addr;
	logic [RW-1:0]                 row_q, row_d, h_last;
	logic                          accept, cfg_hit, cur;
	logic                          left_b, center_b, up_b, first_b;
	logic [1:0]                    rd_data;
	logic                          border, flag0, res0_v, res1_v;
	bmbd_pkg::cell_ctrl_t          shift_ctrl, center_ctrl, first_ctrl;
	bmbd_pkg::push_t               push;
	bmbd_pkg::res_t                res0, res1, d0, out_item;
	logic [bmbd_pkg::FIFO_CW-1:0]  fifo_count;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && ((cfg_index == bmbd_pkg::REG_IMAGE_WIDTH) ||
		(cfg_index == bmbd_pkg::REG_IMAGE_HEIGHT));
	assign in_ready  = (fifo_count <= bmbd_pkg::FIFO_CW'(bmbd_pkg::FIFO_DEPTH - 2));
	assign accept    = in_valid && in_ready;
	assign cur       = (gray != 8'd0);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bmbd_pkg::WIDTH_RESET;
			height_q <= bmbd_pkg::HEIGHT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == bmbd_pkg::REG_IMAGE_WIDTH) begin
				width_q <= cfg_data[bmbd_pkg::WIDTH_W-1:0];
			end
			if (cfg_index == bmbd_pkg::REG_IMAGE_HEIGHT) begin
				height_q <= cfg_data[bmbd_pkg::HEIGHT_W-1:0];
			end
		end
	end

	// last column and row index, zero acts as one, clamp at the maxima
	always_comb begin
		if (width_q == '0) begin
			w_last = '0;
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_last = CW'(MAX_WIDTH - 1);
		end else begin
			w_last = CW'(width_q - bmbd_pkg::WIDTH_W'(1));
		end
		if (height_q == '0) begin
			h_last = '0;
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_last = RW'(MAX_HEIGHT - 1);
		end else begin
			h_last = RW'(height_q - bmbd_pkg::HEIGHT_W'(1));
		end
	end

	// raster position of the next item
	always_comb begin
		col_d = col_q;
		row_d = row_q;
		if (cfg_hit) begin
			col_d = '0;
			row_d = '0;
		end else if (accept) begin
			if (col_q == w_last) begin
				col_d = '0;
				row_d = (row_q == h_last) ? '0 : row_q + RW'(1);
			end else begin
				col_d = col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	// line store: read the right-hand entry of the next item ahead of time
	assign rd_addr = col_d + CW'(1);

	bmbd_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_store (
		.clk     (clk),
		.we      (accept),
		.wr_addr (col_q),
		.wr_data ({center_b, cur}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// window cells of the rows above: left <- center <- store, up <- store
	assign shift_ctrl  = '{load: accept, use_alt: 1'b0};
	assign center_ctrl = '{load: accept, use_alt: (col_q == w_last)};
	assign first_ctrl  = '{load: accept && (col_q == '0), use_alt: 1'b0};

	bmbd_cell u_cell_left (
		.clk      (clk),
		.ctrl     (shift_ctrl),
		.shift_in (center_b),
		.alt_in   (center_b),
		.q        (left_b)
	);

	// at a row wrap the center reloads the first pixel of the row just taken
	bmbd_cell u_cell_center (
		.clk      (clk),
		.ctrl     (center_ctrl),
		.shift_in (rd_data[bmbd_pkg::LS_PREV]),
		.alt_in   ((w_last == '0) ? cur : first_b),
		.q        (center_b)
	);

	bmbd_cell u_cell_up (
		.clk      (clk),
		.ctrl     (shift_ctrl),
		.shift_in (rd_data[bmbd_pkg::LS_OLDER]),
		.alt_in   (rd_data[bmbd_pkg::LS_OLDER]),
		.q        (up_b)
	);

	bmbd_cell u_cell_first (
		.clk      (clk),
		.ctrl     (first_ctrl),
		.shift_in (cur),
		.alt_in   (cur),
		.q        (first_b)
	);

	// boundary test of the pixel one row above the item
	assign border = (row_q == RW'(1)) || (col_q == '0) || (col_q == w_last);
	assign flag0  = center_b && (border ||
		!(up_b && cur && left_b && rd_data[bmbd_pkg::LS_PREV]));
	assign res0_v = (row_q != '0);
	assign res1_v = (row_q == h_last);

	assign res0 = '{col:  bmbd_pkg::COL_W'(col_q),
	                row:  bmbd_pkg::ROW_W'(row_q - RW'(1)),
	                flag: flag0,
	                last: !res1_v};
	assign res1 = '{col:  bmbd_pkg::COL_W'(col_q),
	                row:  bmbd_pkg::ROW_W'(row_q),
	                flag: cur,
	                last: 1'b1};

	// pack results into the queue
	assign d0   = res0_v ? res0 : res1;
	assign push = '{push0: accept && (res0_v || res1_v),
	                push1: accept && res0_v && res1_v};

	bmbd_result_fifo u_result_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.d0         (d0),
		.d1         (res1),
		.pop_ready  (out_ready),
		.item_valid (out_valid),
		.item       (out_item),
		.count      (fifo_count)
	);

	assign pixel_col   = out_item.col;
	assign pixel_row   = out_item.row;
	assign is_boundary = out_item.flag;
	assign last_of_run = out_item.last;

	// checks
	`BMBD_ASSERT_IMP(a_fifo_bound, clk, arst_n, 1'b1, fifo_count <= bmbd_pkg::FIFO_CW'(bmbd_pkg::FIFO_DEPTH))
	`BMBD_ASSERT_NXT(a_frame_wrap, clk, arst_n, accept && !cfg_hit && (col_q == w_last) && (row_q == h_last), (col_q == '0) && (row_q == '0))
	`BMBD_ASSERT_NXT(a_col_step, clk, arst_n, accept && !cfg_hit && (col_q != w_last), (col_q == $past(col_q) + CW'(1)) && (row_q == $past(row_q)))

endmodule

`default_nettype wire

// ===== design/bmbd_cell.sv =====
// One window cell: a foreground bit that shifts in from its neighbor or
// loads an alternate bit at a row wrap. Uses bmbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmbd_cell (
	input  wire                  clk,
	input  bmbd_pkg::cell_ctrl_t ctrl,
	input  wire                  shift_in,
	input  wire                  alt_in,
	output logic                 q
);

	logic bit_q;

	// payload bit, no reset needed
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bit_q <= ctrl.use_alt ? alt_in : shift_in;
		end
	end

	assign q = bit_q;

endmodule

`default_nettype wire

// ===== design/bmbd_line_store.sv =====
// Line store of the two previous rows' foreground bits, one entry per column.
// One write and one registered read per cycle, write-first on collision.
`timescale 1ns / 1ps
`default_nettype none

module bmbd_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire           clk,
	input  wire           we,
	input  wire  [AW-1:0] wr_addr,
	input  wire  [1:0]    wr_data,
	input  wire  [AW-1:0] rd_addr,
	output logic [1:0]    rd_data
);

	logic [1:0] mem_q [DEPTH];
	logic [1:0] rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port with bypass of a same-cycle write
	always_ff @(posedge clk) begin
		if (we && (wr_addr == rd_addr)) begin
			rd_q <= wr_data;
		end else if (32'(rd_addr) < DEPTH) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// ===== design/bmbd_result_fifo.sv =====
// Four-entry result queue, up to two pushes and one pop per cycle.
// Uses bmbd_pkg for the result and push types.
`timescale 1ns / 1ps
`default_nettype none

module bmbd_result_fifo (
	input  wire                           clk,
	input  wire                           arst_n,
	input  bmbd_pkg::push_t               push,
	input  bmbd_pkg::res_t                d0,
	input  bmbd_pkg::res_t                d1,
	input  wire                           pop_ready,
	output logic                          item_valid,
	output bmbd_pkg::res_t                item,
	output logic [bmbd_pkg::FIFO_CW-1:0]  count
);

	bmbd_pkg::res_t                 mem_q [bmbd_pkg::FIFO_DEPTH];
	logic [bmbd_pkg::FIFO_AW-1:0]   wp_q;
	logic [bmbd_pkg::FIFO_AW-1:0]   rp_q;
	logic [bmbd_pkg::FIFO_CW-1:0]   cnt_q;
	logic [bmbd_pkg::FIFO_CW-1:0]   n_push;
	logic                           pop;

	assign pop    = (cnt_q != '0) && pop_ready;
	assign n_push = bmbd_pkg::FIFO_CW'(push.push0) + bmbd_pkg::FIFO_CW'(push.push1);

	// storage
	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wp_q] <= d0;
		end
		if (push.push1) begin
			mem_q[wp_q + bmbd_pkg::FIFO_AW'(1)] <= d1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + bmbd_pkg::FIFO_AW'(n_push);
			rp_q  <= rp_q + bmbd_pkg::FIFO_AW'(pop);
			cnt_q <= cnt_q + n_push - bmbd_pkg::FIFO_CW'(pop);
		end
	end

	assign item_valid = (cnt_q != '0);
	assign item       = mem_q[rp_q];
	assign count      = cnt_q;

endmodule

`default_nettype wire
